FILE: src/asd_pkg.sv
// ----------------------------------------------------------------------------
// asd_pkg
// Shared types, header layout constants and the decimal digit step used by the
// archive stream deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asd_pkg;

  // Part tags carried with every byte.
  localparam logic [1:0] PART_HEADER = 2'd0;
  localparam logic [1:0] PART_NAME   = 2'd1;
  localparam logic [1:0] PART_DATA   = 2'd2;

  // Header byte offsets.
  localparam logic [5:0] HDR_FIRST       = 6'd0;
  localparam logic [5:0] HDR_VERSION     = 6'd4;
  localparam logic [5:0] HDR_TYPE        = 6'd5;
  localparam logic [5:0] HDR_MODE_LO     = 6'd10;
  localparam logic [5:0] HDR_MODE_HI     = 6'd17;
  localparam logic [5:0] HDR_CREATED_LO  = 6'd18;
  localparam logic [5:0] HDR_CREATED_HI  = 6'd25;
  localparam logic [5:0] HDR_MODIFIED_LO = 6'd26;
  localparam logic [5:0] HDR_MODIFIED_HI = 6'd33;
  localparam logic [5:0] HDR_NAMELEN_LO  = 6'd34;
  localparam logic [5:0] HDR_NAMELEN_HI  = 6'd39;
  localparam logic [5:0] HDR_FILELEN_LO  = 6'd40;
  localparam logic [5:0] HDR_LAST        = 6'd47;

  // ASCII characters that the decoders look for.
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [1:0] QUEUE_DEPTH = 2'd2;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_NAME   = 3'b010,
    PH_DATA   = 3'b100
  } phase_t;

  typedef enum logic [3:0] {
    DEC_SKIP   = 4'b0001,
    DEC_DIGITS = 4'b0010,
    DEC_DONE   = 4'b0100,
    DEC_NONE   = 4'b1000
  } dec_state_t;

  typedef struct packed {
    dec_state_t  st;
    logic [19:0] acc;
  } dec_t;

  // One classified byte on its way from the front to the back.
  typedef struct packed {
    logic [1:0] part;
    logic [7:0] data;
    logic       part_last;
    logic       entry_last;
    logic [5:0] index;
  } q_item_t;

  // One step of the space-padded decimal parser.
  function automatic dec_t dec_step(dec_t cur, logic [7:0] b);
    dec_t        res;
    logic        digit;
    logic [19:0] d;
    res   = cur;
    digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    d     = {16'd0, b[3:0]};
    case (cur.st)
      DEC_SKIP: begin
        if (digit) begin
          res.acc = d;
          res.st  = DEC_DIGITS;
        end else if (b != CHAR_SPACE) begin
          res.st = DEC_NONE;
        end
      end
      DEC_DIGITS: begin
        if (digit) begin
          res.acc = (cur.acc << 3) + (cur.acc << 1) + d;
        end else begin
          res.st = DEC_DONE;
        end
      end
      default: res = cur;
    endcase
    return res;
  endfunction

endpackage

FILE: src/archive_stream_deframer.sv
// A byte's result is held first in a queue slot and then in the output register,
// from which it transfers out while result_ready is high.
// Throughput: one byte per cycle while the consumer keeps result_ready high.
// Synchronous reset returns the framing to the start of a header and clears
// all decoded fields; the two-entry queue and the output register empty.
// ----------------------------------------------------------------------------
// archive_stream_deframer
// Tags archive stream bytes with their entry part and decodes header fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module archive_stream_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  byte_value,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  part,
  output logic [7:0]  data_byte,
  output logic        part_last,
  output logic        entry_last,
  output logic [7:0]  entry_type,
  output logic [7:0]  format_version,
  output logic [7:0]  permission_bits,
  output logic [63:0] created_time,
  output logic [63:0] modified_time,
  output logic [19:0] name_length,
  output logic [63:0] file_length,
  output logic        header_error
);
  import asd_pkg::*;

  logic    push_valid;
  logic    push_ready;
  q_item_t push_item;
  logic    q_valid;
  logic    q_ready;
  q_item_t q_item;

  asd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_value (byte_value),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  asd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  asd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_item          (q_item),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .part            (part),
    .data_byte       (data_byte),
    .part_last       (part_last),
    .entry_last      (entry_last),
    .entry_type      (entry_type),
    .format_version  (format_version),
    .permission_bits (permission_bits),
    .created_time    (created_time),
    .modified_time   (modified_time),
    .name_length     (name_length),
    .file_length     (file_length),
    .header_error    (header_error)
  );

endmodule

FILE: src/asd_front.sv
// ----------------------------------------------------------------------------
// asd_front
// Accepts stream bytes, tracks the entry framing and tags each byte with its
// part, its header offset and its end-of-part and end-of-entry marks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_ready,
  input  logic [7:0]       byte_value,
  output logic             push_valid,
  input  logic             push_ready,
  output asd_pkg::q_item_t push_item
);
  import asd_pkg::*;

  phase_t      phase, phase_next;
  logic [5:0]  header_index, header_index_next;
  logic [19:0] name_remaining, name_remaining_next;
  logic [63:0] data_remaining, data_remaining_next;
  dec_t        dec, dec_base, dec_next;
  logic [63:0] len_reg, len_base, len_next;
  logic [5:0]  idx;
  logic [2:0]  lane;
  logic        take;

  assign byte_ready = push_ready;
  assign push_valid = byte_valid;
  assign take       = byte_valid && push_ready;

  always_comb begin
    phase_next          = phase;
    header_index_next   = header_index;
    name_remaining_next = name_remaining;
    data_remaining_next = data_remaining;
    dec_next            = dec;
    len_next            = len_reg;
    idx                 = (header_index > HDR_LAST) ? HDR_FIRST : header_index;
    lane                = 3'(idx - HDR_FILELEN_LO);
    dec_base            = dec;
    len_base            = len_reg;
    push_item.part       = PART_HEADER;
    push_item.data       = byte_value;
    push_item.part_last  = 1'b0;
    push_item.entry_last = 1'b0;
    push_item.index      = idx;

    case (phase)
      PH_NAME: begin
        push_item.part      = PART_NAME;
        name_remaining_next = name_remaining - 20'd1;
        if (name_remaining_next == 20'd0) begin
          push_item.part_last = 1'b1;
          if (data_remaining == 64'd0) begin
            push_item.entry_last = 1'b1;
            phase_next           = PH_HEADER;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        push_item.part      = PART_DATA;
        data_remaining_next = data_remaining - 64'd1;
        if (data_remaining_next == 64'd0) begin
          push_item.part_last  = 1'b1;
          push_item.entry_last = 1'b1;
          phase_next           = PH_HEADER;
        end
      end
      default: begin
        phase_next = PH_HEADER;
        if (idx == HDR_FIRST) begin
          dec_base.st  = DEC_SKIP;
          dec_base.acc = 20'd0;
          len_base     = 64'd0;
        end
        dec_next = dec_base;
        len_next = len_base;
        if (idx >= HDR_NAMELEN_LO && idx <= HDR_NAMELEN_HI) begin
          dec_next = dec_step(dec_base, byte_value);
        end
        if (idx >= HDR_FILELEN_LO && idx <= HDR_LAST) begin
          len_next[{lane, 3'b000} +: 8] = len_base[{lane, 3'b000} +: 8] | byte_value;
        end
        if (idx == HDR_LAST) begin
          push_item.part_last = 1'b1;
          header_index_next   = HDR_FIRST;
          name_remaining_next = dec_next.acc;
          data_remaining_next = len_next;
          if (dec_next.acc != 20'd0) begin
            phase_next = PH_NAME;
          end else if (len_next != 64'd0) begin
            phase_next = PH_DATA;
          end else begin
            push_item.entry_last = 1'b1;
          end
        end else begin
          header_index_next = idx + 6'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_index   <= HDR_FIRST;
      name_remaining <= 20'd0;
      data_remaining <= 64'd0;
      dec.st         <= DEC_SKIP;
      dec.acc        <= 20'd0;
      len_reg        <= 64'd0;
    end else if (take) begin
      phase          <= phase_next;
      header_index   <= header_index_next;
      name_remaining <= name_remaining_next;
      data_remaining <= data_remaining_next;
      dec            <= dec_next;
      len_reg        <= len_next;
    end
  end

endmodule

FILE: src/asd_queue.sv
// ----------------------------------------------------------------------------
// asd_queue
// Two-entry queue of classified bytes between the framing front and the
// header decoding back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  asd_pkg::q_item_t push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output asd_pkg::q_item_t pop_item
);
  import asd_pkg::*;

  q_item_t    slots [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != QUEUE_DEPTH);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/asd_back.sv
// ----------------------------------------------------------------------------
// asd_back
// Decodes the header fields from classified bytes and holds the result
// register that the consumer reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  asd_pkg::q_item_t q_item,
  output logic             result_valid,
  input  logic             result_ready,
  output logic [1:0]       part,
  output logic [7:0]       data_byte,
  output logic             part_last,
  output logic             entry_last,
  output logic [7:0]       entry_type,
  output logic [7:0]       format_version,
  output logic [7:0]       permission_bits,
  output logic [63:0]      created_time,
  output logic [63:0]      modified_time,
  output logic [19:0]      name_length,
  output logic [63:0]      file_length,
  output logic             header_error
);
  import asd_pkg::*;

  // Decode registers; they only move on a transfer out of the queue, so they
  // always match the result currently held.
  logic [7:0]  type_reg, type_next;
  logic [7:0]  version_reg, version_next;
  logic [7:0]  mode_accum, mode_next;
  logic        mode_ended, mode_ended_next;
  logic [63:0] created_reg, created_next;
  logic [63:0] modified_reg, modified_next;
  dec_t        dec, dec_next;
  logic [63:0] length_reg, length_next;
  logic        error_flag, error_next;
  logic        pop;
  logic [7:0]  b;
  logic [2:0]  lane;

  assign q_ready = !result_valid || result_ready;
  assign pop     = q_valid && q_ready;
  assign b       = q_item.data;

  assign entry_type      = type_reg;
  assign format_version  = version_reg;
  assign permission_bits = mode_accum;
  assign created_time    = created_reg;
  assign modified_time   = modified_reg;
  assign name_length     = dec.acc;
  assign file_length     = length_reg;
  assign header_error    = error_flag;

  always_comb begin
    type_next       = type_reg;
    version_next    = version_reg;
    mode_next       = mode_accum;
    mode_ended_next = mode_ended;
    created_next    = created_reg;
    modified_next   = modified_reg;
    dec_next        = dec;
    length_next     = length_reg;
    error_next      = error_flag;
    lane            = q_item.index[2:0];

    if (q_item.index == HDR_FIRST) begin
      type_next       = 8'd0;
      version_next    = 8'd0;
      mode_next       = 8'd0;
      mode_ended_next = 1'b0;
      created_next    = 64'd0;
      modified_next   = 64'd0;
      dec_next.st     = DEC_SKIP;
      dec_next.acc    = 20'd0;
      length_next     = 64'd0;
      error_next      = 1'b0;
    end

    case (q_item.index) inside
      HDR_VERSION: version_next = b;
      HDR_TYPE:    type_next    = b;
      [HDR_MODE_LO:HDR_MODE_HI]: begin
        if (!mode_ended_next) begin
          if (b == CHAR_NUL) begin
            mode_ended_next = 1'b1;
          end else if (b == CHAR_ZERO || b == CHAR_ONE) begin
            mode_next = {mode_next[6:0], b[0]};
          end else begin
            error_next      = 1'b1;
            mode_ended_next = 1'b1;
          end
        end
      end
      [HDR_CREATED_LO:HDR_CREATED_HI]: begin
        lane = 3'(q_item.index - HDR_CREATED_LO);
        created_next[{lane, 3'b000} +: 8] = created_next[{lane, 3'b000} +: 8] | b;
      end
      [HDR_MODIFIED_LO:HDR_MODIFIED_HI]: begin
        lane = 3'(q_item.index - HDR_MODIFIED_LO);
        modified_next[{lane, 3'b000} +: 8] = modified_next[{lane, 3'b000} +: 8] | b;
      end
      [HDR_NAMELEN_LO:HDR_NAMELEN_HI]: begin
        dec_next = dec_step(dec_next, b);
        // A name length field with no digit at all is an error.
        if (q_item.index == HDR_NAMELEN_HI &&
            (dec_next.st == DEC_SKIP || dec_next.st == DEC_NONE)) begin
          error_next = 1'b1;
        end
      end
      [HDR_FILELEN_LO:HDR_LAST]: begin
        lane = 3'(q_item.index - HDR_FILELEN_LO);
        length_next[{lane, 3'b000} +: 8] = length_next[{lane, 3'b000} +: 8] | b;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      part       <= q_item.part;
      data_byte  <= q_item.data;
      part_last  <= q_item.part_last;
      entry_last <= q_item.entry_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      type_reg     <= 8'd0;
      version_reg  <= 8'd0;
      mode_accum   <= 8'd0;
      mode_ended   <= 1'b0;
      created_reg  <= 64'd0;
      modified_reg <= 64'd0;
      dec.st       <= DEC_SKIP;
      dec.acc      <= 20'd0;
      length_reg   <= 64'd0;
      error_flag   <= 1'b0;
    end else begin
      if (pop) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (pop && q_item.part == PART_HEADER) begin
        type_reg     <= type_next;
        version_reg  <= version_next;
        mode_accum   <= mode_next;
        mode_ended   <= mode_ended_next;
        created_reg  <= created_next;
        modified_reg <= modified_next;
        dec          <= dec_next;
        length_reg   <= length_next;
        error_flag   <= error_next;
      end
    end
  end

endmodule
